>>> hdl/dfs_pkg.sv
// Shared types and constants for the spread-spectrum frame spreader.
package dfs_pkg;

    // Symbol kind codes as shown on symbol_kind
    localparam logic [1:0] KIND_ZEROS     = 2'd0;
    localparam logic [1:0] KIND_ZERO_CODE = 2'd1;
    localparam logic [1:0] KIND_ONE_CODE  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ZERO_CODE = 1'b0;
    localparam logic CFG_ONE_CODE  = 1'b1;

    // Symbol counts of the frame sections
    localparam int PRE_SYMBOLS  = 10;
    localparam int DATA_SYMBOLS = 8;
    localparam int POST_SYMBOLS = 8;

    // One queued request: message byte and its frame marks
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } item_t;

endpackage

>>> hdl/dfs_front.sv
// Front end: accepts requests and holds them in a two-entry queue.
module dfs_front
    import dfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       head_valid,
    output item_t      head,
    input  logic       pop
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    // Stall only when both entries are taken
    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{data: data_byte, first: first_byte, last: last_byte};
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hdl/dfs_back.sv
// Back end: walks preamble, data and postamble symbols of the head request.
module dfs_back
    import dfs_pkg::*;
#(
    parameter int CODE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        head_valid,
    input  item_t       head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  symbol_kind,
    output logic [63:0] chip_word,
    output logic        run_end
);

    localparam int CW = CODE_BYTES * 8;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_DATA,
        PH_POST
    } phase_t;

    logic [CW-1:0] zero_code_reg;
    logic [CW-1:0] one_code_reg;
    logic          started_reg;
    phase_t        phase_reg;
    logic [3:0]    idx_reg;
    logic          out_valid_reg;
    logic [1:0]    kind_reg;
    logic [63:0]   word_reg;
    logic          end_reg;

    phase_t        cur_phase;
    logic [3:0]    cur_idx;
    phase_t        phase_next;
    logic [3:0]    idx_next;
    logic [1:0]    kind_next;
    logic [63:0]   word_next;
    logic          item_end;
    logic          load;

    // Position of the head request; a fresh one starts at its first section
    always_comb
    begin
        cur_phase = started_reg ? phase_reg : (head.first ? PH_PRE : PH_DATA);
        cur_idx   = started_reg ? idx_reg : 4'd0;
    end

    // Pick the symbol and the next position
    always_comb
    begin
        kind_next  = KIND_ZEROS;
        item_end   = 1'b0;
        phase_next = cur_phase;
        idx_next   = cur_idx + 4'd1;
        case (cur_phase)
            PH_PRE:
            begin
                if (cur_idx == 4'(PRE_SYMBOLS - 1))
                begin
                    kind_next  = KIND_ZERO_CODE;
                    phase_next = PH_DATA;
                    idx_next   = 4'd0;
                end
                else if (cur_idx == 4'(PRE_SYMBOLS - 2) || !cur_idx[0])
                begin
                    kind_next = KIND_ONE_CODE;
                end
                else
                begin
                    kind_next = KIND_ZEROS;
                end
            end
            PH_DATA:
            begin
                kind_next = head.data[cur_idx[2:0]] ? KIND_ONE_CODE : KIND_ZERO_CODE;
                if (cur_idx == 4'(DATA_SYMBOLS - 1))
                begin
                    idx_next = 4'd0;
                    if (head.last)
                    begin
                        phase_next = PH_POST;
                    end
                    else
                    begin
                        item_end = 1'b1;
                    end
                end
            end
            PH_POST:
            begin
                kind_next = cur_idx[0] ? KIND_ZERO_CODE : KIND_ZEROS;
                if (cur_idx == 4'(POST_SYMBOLS - 1))
                begin
                    item_end = 1'b1;
                    idx_next = 4'd0;
                end
            end
            default:
            begin
                item_end = 1'b1;
                idx_next = 4'd0;
            end
        endcase
    end

    // Map the kind to its chip word
    always_comb
    begin
        case (kind_next)
            KIND_ONE_CODE:  word_next = 64'(one_code_reg);
            KIND_ZERO_CODE: word_next = 64'(zero_code_reg);
            default:        word_next = 64'd0;
        endcase
    end

    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && item_end;

    // Hold the code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_code_reg <= '0;
            one_code_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ZERO_CODE: zero_code_reg <= cfg_data[CW-1:0];
                CFG_ONE_CODE:  one_code_reg  <= cfg_data[CW-1:0];
                default:       zero_code_reg <= zero_code_reg;
            endcase
        end
    end

    // Advance the sequencer and load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            phase_reg     <= PH_DATA;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_ZEROS;
            word_reg      <= 64'd0;
            end_reg       <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            kind_reg      <= kind_next;
            word_reg      <= word_next;
            end_reg       <= item_end;
            started_reg   <= !item_end;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol_kind = kind_reg;
    assign chip_word   = word_reg;
    assign run_end     = end_reg;

endmodule

>>> hdl/dsss_frame_spreader.sv
// Top level of the spread-spectrum frame spreader: request queue and symbol sequencer.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | data_byte, first_byte, last_byte
//  out     | out_valid / out_stall | symbol_kind, chip_word, run_end
//  cfg     | cfg_we                | cfg_index, cfg_data
//
// One symbol leaves per cycle while out_stall is low, so a byte gives 8 symbols,
// 18 with a preamble, 16 with a postamble and 26 with both; the symbol sequencer
// sets this rate. The two-entry queue accepts new bytes while the sequencer is busy.
// The first symbol of a byte is registered on the output after the queue stores it.
// Reset empties the queue, idles the sequencer and zeroes both code registers.
// A stalled output holds its symbol; the sequencer waits with it.
module dsss_frame_spreader
    import dfs_pkg::*;
#(
    parameter int CODE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  symbol_kind,
    output logic [63:0] chip_word,
    output logic        run_end,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    logic  head_valid;
    item_t head;
    logic  pop;

    // Accept and queue requests
    dfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Spread the head request into symbols
    dfs_back #(
        .CODE_BYTES (CODE_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol_kind (symbol_kind),
        .chip_word   (chip_word),
        .run_end     (run_end)
    );

endmodule

>>> hdl/dfs_checker.sv
// Port-level checks for the frame spreader and their binding to the top level.
module dfs_checker
    import dfs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  symbol_kind,
    input logic [63:0] chip_word,
    input logic        run_end
);

    // Hold a stalled output symbol
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol_kind)
            && $stable(chip_word) && $stable(run_end))
        else $error("stalled output symbol changed");

    // Drive only defined kinds
    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> symbol_kind == KIND_ZEROS || symbol_kind == KIND_ZERO_CODE
            || symbol_kind == KIND_ONE_CODE)
        else $error("undefined symbol kind");

    // Send an empty chip word for an all-zeros symbol
    a_zeros_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && symbol_kind == KIND_ZEROS |-> chip_word == 64'd0)
        else $error("all-zeros symbol with chips set");

    // End a run on a code symbol only, never on an all-zeros symbol
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_end |-> symbol_kind != KIND_ZEROS)
        else $error("run ends on an all-zeros symbol");

endmodule

bind dsss_frame_spreader dfs_checker u_dfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol_kind (symbol_kind),
    .chip_word   (chip_word),
    .run_end     (run_end)
);
